@@ sv/bis_pkg.sv @@
// ============================================================================
// Bilinear scaler package
// Shared constants, derived widths and register index codes for the
// bilinear image scaler and its frame memory.
// ============================================================================
package bis_pkg;

    // Frame geometry and fixed-point format.
    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int FRAC_BITS   = 8;

    // Field widths of the ports.
    localparam int PIX_W       = 8;
    localparam int COORD_W     = 10;
    localparam int SRC_SZ_W    = 9;
    localparam int DST_SZ_W    = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;

    // Frame memory.
    localparam int X_W         = $clog2(MAX_WIDTH);
    localparam int Y_W         = $clog2(MAX_HEIGHT);
    localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(FRAME_DEPTH);
    localparam int BASE_W      = Y_W + SRC_SZ_W;

    // Coordinate mapping divider.
    localparam int PROD_W      = COORD_W + SRC_SZ_W;
    localparam int DIVD_W      = PROD_W + FRAC_BITS;
    localparam int CNT_W       = $clog2(DIVD_W);
    localparam int REM_W       = DST_SZ_W;
    localparam int POS_W       = PROD_W + 1;

    // Blend datapath.
    localparam int WGT_W       = FRAC_BITS + 1;
    localparam int ROW_SUM_W   = WGT_W + PIX_W + 1;
    localparam int NUM_W       = WGT_W + ROW_SUM_W + 1;
    localparam int RND_SH      = 2 * FRAC_BITS + 2;
    localparam int RES_W       = NUM_W - RND_SH;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_DST_WIDTH  = 2'd2,
        CFG_DST_HEIGHT = 2'd3
    } t_cfg_idx;

    // Item kinds carried by the mode field.
    typedef enum logic {
        MODE_WRITE = 1'b0,
        MODE_READ  = 1'b1
    } t_mode;

endpackage

@@ sv/bis_ram.sv @@
// ============================================================================
// Generic single-port RAM
// One read or write per cycle; read data is registered.
// ============================================================================
module bis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/image_bilinear_scaler.sv @@
// ============================================================================
// Bilinear image scaler
// Stores an 8-bit source frame and returns bilinearly blended pixels of a
// scaled destination image, one destination pixel per read item.
// ============================================================================
//
// The block takes one item at a time. A write item (mode 0) stores one
// source pixel, with its column and row clamped to the last column and row
// of the source frame, through the accept and then the memory write. A
// read item (mode 1) maps the destination column and row to source
// positions with eight fraction bits, fetches the four neighbors from the
// single-port frame memory and blends them; it produces exactly one result
// item. Its steps are the restoring divider that computes col*src_w/dst_w
// and row*src_h/dst_h (both in parallel, one quotient bit per cycle), the
// frame memory reads, one per neighbor plus the read latency, and the
// blend. A finished result waits in an output register, so a new item may
// be accepted while the previous result is still pending.
// Configuration registers are written through their own channel, which is
// always ready; they must only change while the block is idle. The frame
// memory is not cleared at reset: reading a pixel that was never written
// returns an undefined value.
//
module image_bilinear_scaler
    import bis_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    // Input item channel.
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_mode,
    input  logic [COORD_W-1:0]    i_col,
    input  logic [COORD_W-1:0]    i_row,
    input  logic [PIX_W-1:0]      i_value,

    // Result item channel.
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PIX_W-1:0]      o_pixel_out
);

    // One-hot sequencer states.
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_WR    = 9'b000000010,
        S_MULT  = 9'b000000100,
        S_DIV   = 9'b000001000,
        S_POS   = 9'b000010000,
        S_FETCH = 9'b000100000,
        S_MIXA  = 9'b001000000,
        S_MIXB  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    localparam logic [WGT_W-1:0] WGT_ONE  = WGT_W'(1) << FRAC_BITS;
    localparam logic [NUM_W-1:0] RND_HALF = NUM_W'(1) << (RND_SH - 1);
    localparam logic [RES_W-1:0] PIX_MAX  = RES_W'((1 << PIX_W) - 1);

    // Clamp a coordinate to the last valid index.
    function automatic logic [SRC_SZ_W-1:0] sat_coord(
        input logic [POS_W-1:0]    v,
        input logic [SRC_SZ_W-1:0] last
    );
        if (v > POS_W'(last)) begin
            return last;
        end
        return SRC_SZ_W'(v);
    endfunction

    t_state r_state, n_state;

    // Configuration registers.
    logic [SRC_SZ_W-1:0] r_src_w, r_src_h;
    logic [DST_SZ_W-1:0] r_dst_w, r_dst_h;

    // Effective sizes after the zero and oversize rules.
    logic [SRC_SZ_W-1:0] src_w_eff, src_h_eff;
    logic [SRC_SZ_W-1:0] src_w_last, src_h_last;
    logic [DST_SZ_W-1:0] dst_w_eff, dst_h_eff;

    // Item capture.
    logic               r_mode;
    logic [COORD_W-1:0] r_col, r_row;
    logic [PIX_W-1:0]   r_value;

    // Divider state: the dividend shifts out at the top while the quotient
    // shifts in at the bottom.
    logic [DIVD_W-1:0] r_qx, r_qy;
    logic [REM_W-1:0]  r_rem_x, r_rem_y;
    logic [CNT_W-1:0]  r_div_cnt;

    logic [REM_W:0]    trial_x, trial_y, diff_x, diff_y;
    logic              ge_x, ge_y;

    // Neighbor coordinates and weights.
    logic [X_W-1:0]    r_x0, r_x1;
    logic [Y_W-1:0]    r_y0, r_y1;
    logic [WGT_W-1:0]  r_ax, r_bx, r_ay, r_by;
    logic [POS_W-1:0]  rnd_x, rnd_y;

    // Fetch and blend.
    logic [2:0]            r_fcnt;
    logic [1:0]            issue_idx, cap_idx;
    logic [ROW_SUM_W-1:0]  r_p1, r_p2;
    logic [WGT_W+PIX_W-1:0] cap_prod;
    logic [NUM_W-1:0]      r_num, num_full;
    logic [RES_W-1:0]      res_full;
    logic [PIX_W-1:0]      r_res;

    // Output register.
    logic             r_out_valid;
    logic [PIX_W-1:0] r_pixel;

    // Frame memory port.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [PIX_W-1:0]  ram_rdata;
    logic [Y_W-1:0]    mul_y;
    logic [X_W-1:0]    mul_x;
    logic [BASE_W-1:0] row_base;

    logic in_acc;
    logic out_free;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_pixel_out = r_pixel;

    // ------------------------------------------------------------------
    // Effective sizes. A zero size acts as one; a source size above the
    // frame store acts as the store's size.
    // ------------------------------------------------------------------
    always_comb begin
        if (r_src_w == '0) begin
            src_w_eff = SRC_SZ_W'(1);
        end else if (r_src_w > SRC_SZ_W'(MAX_WIDTH)) begin
            src_w_eff = SRC_SZ_W'(MAX_WIDTH);
        end else begin
            src_w_eff = r_src_w;
        end
        if (r_src_h == '0) begin
            src_h_eff = SRC_SZ_W'(1);
        end else if (r_src_h > SRC_SZ_W'(MAX_HEIGHT)) begin
            src_h_eff = SRC_SZ_W'(MAX_HEIGHT);
        end else begin
            src_h_eff = r_src_h;
        end
        dst_w_eff = (r_dst_w == '0) ? DST_SZ_W'(1) : r_dst_w;
        dst_h_eff = (r_dst_h == '0) ? DST_SZ_W'(1) : r_dst_h;
    end

    assign src_w_last = src_w_eff - SRC_SZ_W'(1);
    assign src_h_last = src_h_eff - SRC_SZ_W'(1);

    // ------------------------------------------------------------------
    // Restoring division step, one quotient bit per cycle for each axis.
    // The remainder always stays below the divisor, so it fits REM_W bits.
    // ------------------------------------------------------------------
    assign trial_x = {r_rem_x, r_qx[DIVD_W-1]};
    assign trial_y = {r_rem_y, r_qy[DIVD_W-1]};
    assign ge_x    = (trial_x >= {1'b0, dst_w_eff});
    assign ge_y    = (trial_y >= {1'b0, dst_h_eff});
    assign diff_x  = trial_x - {1'b0, dst_w_eff};
    assign diff_y  = trial_y - {1'b0, dst_h_eff};

    // Rounded integer position: the fraction's top bit rounds half up.
    assign rnd_x = {1'b0, r_qx[DIVD_W-1:FRAC_BITS]} + POS_W'(r_qx[FRAC_BITS-1]);
    assign rnd_y = {1'b0, r_qy[DIVD_W-1:FRAC_BITS]} + POS_W'(r_qy[FRAC_BITS-1]);

    // ------------------------------------------------------------------
    // Frame memory address. The one row multiplier serves both the
    // write item and the four neighbor reads; the row pitch is the
    // effective source width.
    // ------------------------------------------------------------------
    assign issue_idx = r_fcnt[1:0];
    assign cap_idx   = 2'(r_fcnt - 3'd1);

    always_comb begin
        if (r_state == S_WR) begin
            mul_y = Y_W'(sat_coord(POS_W'(r_row), src_h_last));
            mul_x = X_W'(sat_coord(POS_W'(r_col), src_w_last));
        end else begin
            mul_y = issue_idx[1] ? r_y1 : r_y0;
            mul_x = issue_idx[0] ? r_x1 : r_x0;
        end
    end

    assign row_base = BASE_W'(mul_y) * BASE_W'(src_w_eff);
    assign ram_addr = ADDR_W'(row_base + BASE_W'(mul_x));
    assign ram_we   = (r_state == S_WR);

    bis_ram #(
        .WIDTH (PIX_W),
        .DEPTH (FRAME_DEPTH)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_value),
        .o_rdata (ram_rdata)
    );

    // Each returning neighbor is weighted as it arrives: the first pixel of
    // a row pair takes the 0.5 + f/2 weight, the second the 0.5 - f/2 one.
    assign cap_prod = (WGT_W+PIX_W)'(cap_idx[0] ? r_bx : r_ax) * (WGT_W+PIX_W)'(ram_rdata);

    // Final column blend and round half up.
    assign num_full = r_num + NUM_W'(r_by) * NUM_W'(r_p2) + RND_HALF;
    assign res_full = num_full[NUM_W-1:RND_SH];

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_mode == MODE_READ) ? S_MULT : S_WR;
                end
            end
            S_WR: begin
                n_state = S_IDLE;
            end
            S_MULT: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_div_cnt == CNT_W'(DIVD_W - 1)) begin
                    n_state = S_POS;
                end
            end
            S_POS: begin
                n_state = S_FETCH;
            end
            S_FETCH: begin
                if (r_fcnt == 3'd4) begin
                    n_state = S_MIXA;
                end
            end
            S_MIXA: begin
                n_state = S_MIXB;
            end
            S_MIXB: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_src_w     <= SRC_SZ_W'(256);
            r_src_h     <= SRC_SZ_W'(256);
            r_dst_w     <= DST_SZ_W'(256);
            r_dst_h     <= DST_SZ_W'(256);
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_SRC_WIDTH:  r_src_w <= i_cfg_data[SRC_SZ_W-1:0];
                    CFG_SRC_HEIGHT: r_src_h <= i_cfg_data[SRC_SZ_W-1:0];
                    CFG_DST_WIDTH:  r_dst_w <= i_cfg_data[DST_SZ_W-1:0];
                    CFG_DST_HEIGHT: r_dst_h <= i_cfg_data[DST_SZ_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode  <= i_mode;
            r_col   <= i_col;
            r_row   <= i_row;
            r_value <= i_value;
        end

        case (r_state)
            S_MULT: begin
                // Scaled position numerators, shifted up by the fraction bits.
                r_qx      <= {PROD_W'(r_col) * PROD_W'(src_w_eff), FRAC_BITS'(0)};
                r_qy      <= {PROD_W'(r_row) * PROD_W'(src_h_eff), FRAC_BITS'(0)};
                r_rem_x   <= '0;
                r_rem_y   <= '0;
                r_div_cnt <= '0;
            end
            S_DIV: begin
                r_rem_x   <= ge_x ? diff_x[REM_W-1:0] : trial_x[REM_W-1:0];
                r_rem_y   <= ge_y ? diff_y[REM_W-1:0] : trial_y[REM_W-1:0];
                r_qx      <= {r_qx[DIVD_W-2:0], ge_x};
                r_qy      <= {r_qy[DIVD_W-2:0], ge_y};
                r_div_cnt <= r_div_cnt + CNT_W'(1);
            end
            S_POS: begin
                r_x0   <= X_W'(sat_coord(rnd_x, src_w_last));
                r_x1   <= X_W'(sat_coord(rnd_x + POS_W'(1), src_w_last));
                r_y0   <= Y_W'(sat_coord(rnd_y, src_h_last));
                r_y1   <= Y_W'(sat_coord(rnd_y + POS_W'(1), src_h_last));
                r_ax   <= WGT_ONE + WGT_W'(r_qx[FRAC_BITS-1:0]);
                r_bx   <= WGT_ONE - WGT_W'(r_qx[FRAC_BITS-1:0]);
                r_ay   <= WGT_ONE + WGT_W'(r_qy[FRAC_BITS-1:0]);
                r_by   <= WGT_ONE - WGT_W'(r_qy[FRAC_BITS-1:0]);
                r_fcnt <= '0;
            end
            S_FETCH: begin
                r_fcnt <= r_fcnt + 3'd1;
                if (r_fcnt != 3'd0) begin
                    if (!cap_idx[1]) begin
                        r_p1 <= cap_idx[0] ? r_p1 + ROW_SUM_W'(cap_prod)
                                           : ROW_SUM_W'(cap_prod);
                    end else begin
                        r_p2 <= cap_idx[0] ? r_p2 + ROW_SUM_W'(cap_prod)
                                           : ROW_SUM_W'(cap_prod);
                    end
                end
            end
            S_MIXA: begin
                r_num <= NUM_W'(r_ay) * NUM_W'(r_p1);
            end
            S_MIXB: begin
                r_res <= (res_full > PIX_MAX) ? PIX_MAX[PIX_W-1:0] : res_full[PIX_W-1:0];
            end
            default: begin
            end
        endcase

        if (r_state == S_OUT && out_free) begin
            r_pixel <= r_res;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A write item never produces a result item.
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_mode == MODE_WRITE) |=> !$rose(r_out_valid))
        else $error("result raised after a write item");

    // The divider remainders stay below their divisors.
    a_rem_x_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem_x < dst_w_eff))
        else $error("column divider remainder out of range");

    a_rem_y_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem_y < dst_h_eff))
        else $error("row divider remainder out of range");

    // The frame memory is written only for a captured write item.
    a_write_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_mode == MODE_WRITE && $past(in_acc)))
        else $error("frame memory written outside a write item");

endmodule
